// ----- rtl/cswm_pkg.sv -----
`timescale 1ns / 1ps
package cswm_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_HOLD     = 2'd1;
  localparam logic [1:0] CFG_REPRESS  = 2'd2;

  localparam int CFG_DATA_W = 16;

  localparam logic [9:0]  DEBOUNCE_RST = 10'd50;
  localparam logic [15:0] HOLD_RST     = 16'd2000;
  localparam logic [9:0]  REPRESS_RST  = 10'd500;

  // millisecond correction: 24 thousandths per tick
  localparam logic [9:0] FRAC_STEP = 10'd24;
  localparam logic [9:0] FRAC_MOD  = 10'd1000;

  // display modes
  localparam logic [2:0] MODE_MIN_SEC   = 3'd0;
  localparam logic [2:0] MODE_HOUR_MIN  = 3'd1;
  localparam logic [2:0] MODE_ADJ_HOUR  = 3'd2;
  localparam logic [2:0] MODE_ADJ_MIN   = 3'd3;
  localparam logic [2:0] MODE_ADJ_SEC   = 3'd4;
  localparam logic [2:0] MODE_WATCH_RST = 3'd5;
  localparam logic [2:0] MODE_WATCH_RUN = 3'd6;
  localparam logic [2:0] MODE_UNUSED    = 3'd7;

  localparam logic [5:0] SIXTY      = 6'd60;
  localparam logic [4:0] TWENTYFOUR = 5'd24;

  // event queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic second_pulse;
    logic mode_button;
    logic inc_button;
  } cswm_in_t;

  typedef struct packed {
    logic [2:0] mode_now;
    logic [5:0] display_low;
    logic [5:0] display_high;
    logic       dot_low;
    logic       adjust_lamp_out;
  } cswm_out_t;

  // one classified tick
  typedef struct packed {
    logic pulse;
    logic short_press;
    logic long_hold;
    logic inc_edge;
  } cswm_evt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cswm_qstat_t;

endpackage

// ----- rtl/clock_stopwatch_mode_controller_top.sv -----
`timescale 1ns / 1ps
// Path: an accepted tick transaction is written into the queue, then popped into the back end's result register.
// Throughput: one tick per cycle while out_ready holds, limited by the back end's single result register.
// Queue: two entries between the front (timing, button classification) and the back.
// Reset: synchronous, active high; clock 11:27:00, mode 0, registers 50/2000/500 ms.
// No clearing pass: the block accepts ticks as soon as reset is released.
module clock_stopwatch_mode_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cswm_pkg::cswm_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cswm_pkg::cswm_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [cswm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cswm_pkg::*;

  cswm_evt_t   front_evt;
  cswm_evt_t   back_evt;
  cswm_qstat_t qstat;
  logic        push;
  logic        pop;

  // Front takes a tick transaction whenever the queue has room.
  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  // Back runs one event when the result register is free or being drained.
  assign pop = !qstat.empty && (!out_valid || out_ready);

  // Front: corrected ms count, press timing, debounce, hold, edge detection.
  cswm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .tick      (in_data),
    .evt       (front_evt)
  );

  // Short queue of classified events.
  cswm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_evt),
    .pop       (pop),
    .pop_data  (back_evt),
    .stat      (qstat)
  );

  // Back: mode machine, time of day, set registers, stopwatch, display select.
  cswm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .pop    (pop),
    .evt    (back_evt),
    .result (out_data)
  );

  // Output valid: set on pop, cleared once the transaction is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Mode 7 is never entered from reset.
  a_no_mode7: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.mode_now != MODE_UNUSED)
    else $error("mode 7 reached");

  // Displayed values stay inside 0..59.
  a_disp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.display_low < SIXTY) && (out_data.display_high < SIXTY))
    else $error("display value out of range");

  // Queue never underflows.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // A pending result is held until taken.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

endmodule

// ----- rtl/cswm_front.sv -----
`timescale 1ns / 1ps
module cswm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [cswm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                         push,
  input  cswm_pkg::cswm_in_t           tick,
  output cswm_pkg::cswm_evt_t          evt
);
  import cswm_pkg::*;

  logic [9:0]  debounce_ms;
  logic [15:0] hold_ms;
  logic [9:0]  repress_ms;

  // ms_up / frac_up hold the values the count takes on the next tick
  logic [31:0] ms_up;
  logic [9:0]  frac_up;
  logic [31:0] press_time;
  logic        mode_button_last;
  logic        inc_button_last;
  logic        ignore_release;

  logic [9:0]  frac_sum;
  logic        frac_carry;
  logic [31:0] ms_up_next;
  logic [9:0]  frac_up_next;
  logic        press_edge;
  logic        release_edge;
  logic [31:0] pt_eff;
  logic [31:0] elapsed;
  logic        release_ok;
  logic        hold_fire;
  logic [31:0] press_time_next;
  logic        ignore_next;

  always_comb begin
    frac_sum     = frac_up + FRAC_STEP;
    frac_carry   = (frac_sum >= FRAC_MOD);
    frac_up_next = frac_carry ? frac_sum - FRAC_MOD : frac_sum;
    ms_up_next   = ms_up + (frac_carry ? 32'd2 : 32'd1);
  end

  always_comb begin
    press_edge   = !tick.mode_button && mode_button_last;
    release_edge = tick.mode_button && !mode_button_last;
    // press time restarts on a press edge after the re-press gap
    if (press_edge && ((ms_up - press_time) > {22'd0, repress_ms})) begin
      pt_eff = ms_up;
    end else begin
      pt_eff = press_time;
    end
    elapsed    = ms_up - pt_eff;
    release_ok = release_edge && (elapsed > {22'd0, debounce_ms});
    hold_fire  = !tick.mode_button && (elapsed > {16'd0, hold_ms});

    press_time_next = hold_fire ? ms_up : pt_eff;
    ignore_next     = ignore_release;
    if (release_ok) begin
      ignore_next = 1'b0;
    end
    if (hold_fire) begin
      ignore_next = 1'b1;
    end

    evt.pulse       = tick.second_pulse;
    evt.short_press = release_ok && !ignore_release;
    evt.long_hold   = hold_fire;
    evt.inc_edge    = !tick.inc_button && inc_button_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= DEBOUNCE_RST;
      hold_ms          <= HOLD_RST;
      repress_ms       <= REPRESS_RST;
      ms_up            <= 32'd1;
      frac_up          <= FRAC_STEP;
      press_time       <= '0;
      mode_button_last <= 1'b1;
      inc_button_last  <= 1'b1;
      ignore_release   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: debounce_ms <= cfg_data[9:0];
          CFG_HOLD:     hold_ms     <= cfg_data[15:0];
          CFG_REPRESS:  repress_ms  <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (push) begin
        ms_up            <= ms_up_next;
        frac_up          <= frac_up_next;
        press_time       <= press_time_next;
        mode_button_last <= tick.mode_button;
        inc_button_last  <= tick.inc_button;
        ignore_release   <= ignore_next;
      end
    end
  end

endmodule

// ----- rtl/cswm_queue.sv -----
`timescale 1ns / 1ps
module cswm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cswm_pkg::cswm_evt_t  push_data,
  input  logic                 pop,
  output cswm_pkg::cswm_evt_t  pop_data,
  output cswm_pkg::cswm_qstat_t stat
);
  import cswm_pkg::*;

  cswm_evt_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/cswm_back.sv -----
`timescale 1ns / 1ps
module cswm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop,
  input  cswm_pkg::cswm_evt_t evt,
  output cswm_pkg::cswm_out_t result
);
  import cswm_pkg::*;

  logic [2:0] mode;
  logic       adjust_lamp;
  logic [5:0] clock_second, clock_minute;
  logic [4:0] clock_hour;
  logic [5:0] set_second, set_minute;
  logic [4:0] set_hour;
  logic [5:0] watch_second, watch_minute;
  logic       watch_running;

  logic [2:0] mode_next;
  logic       adjust_lamp_next;
  logic [5:0] clock_second_next, clock_minute_next;
  logic [4:0] clock_hour_next;
  logic [5:0] set_second_next, set_minute_next;
  logic [4:0] set_hour_next;
  logic [5:0] watch_second_next, watch_minute_next;
  logic       watch_running_next;
  logic [5:0] lo, hi;

  always_comb begin
    mode_next          = mode;
    adjust_lamp_next   = adjust_lamp;
    clock_second_next  = clock_second;
    clock_minute_next  = clock_minute;
    clock_hour_next    = clock_hour;
    set_second_next    = set_second;
    set_minute_next    = set_minute;
    set_hour_next      = set_hour;
    watch_second_next  = watch_second;
    watch_minute_next  = watch_minute;
    watch_running_next = watch_running;
    lo                 = '0;
    hi                 = '0;

    if (evt.pulse) begin
      clock_second_next = clock_second + 6'd1;
      if (clock_second_next >= SIXTY) begin
        clock_second_next = '0;
        clock_minute_next = clock_minute + 6'd1;
        if (clock_minute_next >= SIXTY) begin
          clock_minute_next = '0;
          clock_hour_next   = clock_hour + 5'd1;
        end
        if (clock_hour_next >= TWENTYFOUR) begin
          clock_hour_next = '0;
        end
      end
      if (mode == MODE_WATCH_RUN && watch_running) begin
        watch_second_next = watch_second + 6'd1;
        if (watch_second_next >= SIXTY) begin
          watch_second_next = '0;
          watch_minute_next = (watch_minute + 6'd1 >= SIXTY) ? 6'd0 : watch_minute + 6'd1;
        end
      end
    end

    if (evt.short_press) begin
      unique case (mode)
        MODE_MIN_SEC:   mode_next = MODE_HOUR_MIN;
        MODE_HOUR_MIN:  mode_next = MODE_MIN_SEC;
        MODE_ADJ_HOUR:  mode_next = MODE_ADJ_MIN;
        MODE_ADJ_MIN:   mode_next = MODE_ADJ_SEC;
        MODE_ADJ_SEC:   mode_next = MODE_ADJ_HOUR;
        MODE_WATCH_RST: mode_next = MODE_WATCH_RUN;
        MODE_WATCH_RUN: mode_next = MODE_WATCH_RST;
        default:        mode_next = MODE_WATCH_RUN;
      endcase
    end

    // short press and long hold never come in the same tick
    if (evt.long_hold) begin
      unique case (mode) inside
        MODE_ADJ_MIN, MODE_ADJ_SEC: begin
          clock_second_next = set_second;
          clock_minute_next = set_minute;
          clock_hour_next   = set_hour;
          mode_next         = (mode == MODE_ADJ_MIN) ? MODE_HOUR_MIN : MODE_MIN_SEC;
          adjust_lamp_next  = 1'b0;
        end
        MODE_ADJ_HOUR: mode_next = MODE_WATCH_RST;
        MODE_MIN_SEC, MODE_HOUR_MIN: begin
          set_second_next  = clock_second_next;
          set_minute_next  = clock_minute_next;
          set_hour_next    = clock_hour_next;
          mode_next        = MODE_ADJ_HOUR;
          adjust_lamp_next = 1'b1;
        end
        default: mode_next = MODE_MIN_SEC;
      endcase
    end

    unique case (mode_next)
      MODE_MIN_SEC: begin
        lo = clock_second_next;
        hi = clock_minute_next;
      end
      MODE_HOUR_MIN: begin
        lo = clock_minute_next;
        hi = {1'b0, clock_hour_next};
      end
      MODE_ADJ_HOUR: begin
        if (evt.inc_edge) begin
          set_hour_next = (set_hour_next + 5'd1 >= TWENTYFOUR) ? 5'd0 : set_hour_next + 5'd1;
        end
        lo = set_minute_next;
        hi = {1'b0, set_hour_next};
      end
      MODE_ADJ_MIN: begin
        if (evt.inc_edge) begin
          set_minute_next = (set_minute_next + 6'd1 >= SIXTY) ? 6'd0 : set_minute_next + 6'd1;
        end
        lo = set_minute_next;
        hi = {1'b0, set_hour_next};
      end
      MODE_ADJ_SEC: begin
        if (evt.inc_edge) begin
          set_second_next = (set_second_next + 6'd1 >= SIXTY) ? 6'd0 : set_second_next + 6'd1;
        end
        lo = set_second_next;
        hi = set_minute_next;
      end
      MODE_WATCH_RST: begin
        watch_second_next  = '0;
        watch_minute_next  = '0;
        watch_running_next = 1'b0;
      end
      MODE_WATCH_RUN: begin
        if (evt.inc_edge) begin
          watch_running_next = !watch_running_next;
        end
        lo = watch_second_next;
        hi = watch_minute_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_MIN_SEC;
      adjust_lamp   <= 1'b0;
      clock_second  <= 6'd0;
      clock_minute  <= 6'd27;
      clock_hour    <= 5'd11;
      set_second    <= '0;
      set_minute    <= '0;
      set_hour      <= '0;
      watch_second  <= '0;
      watch_minute  <= '0;
      watch_running <= 1'b0;
    end else if (pop) begin
      mode          <= mode_next;
      adjust_lamp   <= adjust_lamp_next;
      clock_second  <= clock_second_next;
      clock_minute  <= clock_minute_next;
      clock_hour    <= clock_hour_next;
      set_second    <= set_second_next;
      set_minute    <= set_minute_next;
      set_hour      <= set_hour_next;
      watch_second  <= watch_second_next;
      watch_minute  <= watch_minute_next;
      watch_running <= watch_running_next;
    end
  end

  // result register, loaded on every pop
  always_ff @(posedge clk) begin
    if (pop) begin
      result.mode_now        <= mode_next;
      result.display_low     <= lo;
      result.display_high    <= hi;
      result.dot_low         <= (mode_next >= MODE_ADJ_MIN) && (mode_next <= MODE_WATCH_RUN);
      result.adjust_lamp_out <= adjust_lamp_next;
    end
  end

endmodule
